@@ design/lsf_pkg.sv @@
// Shared types, constants and helpers for the learning switch forwarder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lsf_pkg;

	localparam int unsigned PORTS_DEF         = 8;
	localparam int unsigned TABLE_ENTRIES_DEF = 16;
	localparam int unsigned QUEUE_DEPTH       = 4;

	localparam int unsigned MAC_W    = 48;
	localparam int unsigned PORT_W   = 3;
	localparam int unsigned MASK_W   = 8;
	localparam int unsigned BYTES_W  = 16;
	localparam int unsigned PCOUNT_W = 4;
	localparam int unsigned FLAGS_W  = 2;
	localparam int unsigned S_DATA_W = 120;

	localparam logic [BYTES_W-1:0]  MIN_FRAME_BYTES = 16'd12;
	localparam logic [PCOUNT_W-1:0] PORT_COUNT_RST  = 4'd8;
	localparam logic [MAC_W-1:0]    BROADCAST_MAC   = {MAC_W{1'b1}};

	// Header as it travels from the front end to the table engine.
	typedef struct packed {
		logic [PORT_W-1:0] ingress;
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic              short_frame;
		logic              bcast;
		logic              same_mac;
	} lsf_item_t;

	// Ports 0 .. n-1 are active, with n clamped to the port count of the build.
	function automatic logic [MASK_W-1:0] active_mask(input logic [PCOUNT_W-1:0] pc,
		input int unsigned ports);
		logic [PCOUNT_W-1:0] n;
		logic [MASK_W:0]     one;
		n   = (pc > PCOUNT_W'(ports)) ? PCOUNT_W'(ports) : pc;
		one = (MASK_W+1)'(1) << n;
		return MASK_W'(one - (MASK_W+1)'(1));
	endfunction

endpackage

@@ design/lsf_fifo.sv @@
// Short queue of classified headers between the front end and the table engine.
// Depends on lsf_pkg for the header type.
`timescale 1ns / 1ps

module lsf_fifo import lsf_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lsf_item_t wdata,
	output logic      full,
	input  logic      pop,
	output lsf_item_t rdata,
	output logic      empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	lsf_item_t           mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/lsf_front.sv @@
// Front end: takes header transfers, classifies them and feeds the queue.
// Depends on lsf_pkg for field widths and the header type.
`timescale 1ns / 1ps

module lsf_front import lsf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	output logic                push,
	output lsf_item_t           item,
	input  logic                full
);

	logic [PORT_W-1:0]  ingress;
	logic [MAC_W-1:0]   src_mac;
	logic [MAC_W-1:0]   dst_mac;
	logic [BYTES_W-1:0] frame_bytes;
	logic               vld_s1;
	lsf_item_t          item_s1;

	assign ingress     = s_axis_tdata[2:0];
	assign src_mac     = s_axis_tdata[50:3];
	assign dst_mac     = s_axis_tdata[98:51];
	assign frame_bytes = s_axis_tdata[114:99];

	assign push          = vld_s1 && !full;
	assign item          = item_s1;
	assign s_axis_tready = !vld_s1 || !full;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.ingress     <= ingress;
			item_s1.src_mac     <= src_mac;
			item_s1.dst_mac     <= dst_mac;
			item_s1.short_frame <= (frame_bytes < MIN_FRAME_BYTES);
			item_s1.bcast       <= (dst_mac == BROADCAST_MAC);
			item_s1.same_mac    <= (src_mac == dst_mac);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

endmodule

@@ design/lsf_back.sv @@
// Table engine: scans the address table, learns the source, decides the egress ports.
// Depends on lsf_pkg for the header type and the active port mask helper.
`timescale 1ns / 1ps

module lsf_back import lsf_pkg::*; #(
	parameter int unsigned PORTS         = PORTS_DEF,
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PCOUNT_W-1:0] port_count,
	input  logic                empty,
	input  lsf_item_t           qdata,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [MASK_W-1:0]   out_mask,
	output logic                out_flooded,
	output logic                out_dropped
);

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_WRITE = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [MAC_W-1:0]  mac_mem [TABLE_ENTRIES];
	logic [PORT_W-1:0] port_mem [TABLE_ENTRIES];

	logic [1:0]        state_q;
	lsf_item_t         item_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  rp_q;
	logic              rvld_s1;
	logic [IDX_W-1:0]  ridx_s1;
	logic [MAC_W-1:0]  rmac_s1;
	logic [PORT_W-1:0] rport_s1;
	logic              src_hit_q;
	logic [IDX_W-1:0]  src_idx_q;
	logic              dst_hit_q;
	logic [IDX_W-1:0]  dst_idx_q;
	logic [PORT_W-1:0] dst_port_q;
	logic [MASK_W-1:0] res_mask_q;
	logic              res_flood_q;
	logic              res_drop_q;
	logic              out_vld_q;
	logic [MASK_W-1:0] out_mask_q;
	logic              out_flood_q;
	logic              out_drop_q;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [MASK_W-1:0] act;
	logic [MASK_W-1:0] fwd_mask;
	logic              fwd_flood;
	logic              emit_go;

	assign pop     = (state_q == S_IDLE) && !empty;
	assign rd_en   = (state_q == S_SCAN) && (scan_q < fill_q);
	assign rd_addr = scan_q[IDX_W-1:0];
	assign wr_en   = (state_q == S_WRITE);
	assign wr_addr = src_hit_q ? src_idx_q : rp_q;
	assign emit_go = (state_q == S_EMIT) && (!out_vld_q || out_ready);

	assign out_valid   = out_vld_q;
	assign out_mask    = out_mask_q;
	assign out_flooded = out_flood_q;
	assign out_dropped = out_drop_q;

	// The destination counts as known when it equals the source being learned, or
	// when it was found and its entry is not the one the new source overwrites.
	always_comb begin
		act = active_mask(port_count, PORTS);
		if (item_q.bcast) begin
			fwd_flood = 1'b1;
			fwd_mask  = act & ~(MASK_W'(1) << item_q.ingress);
		end else if (item_q.same_mac) begin
			fwd_flood = 1'b0;
			fwd_mask  = act & (MASK_W'(1) << item_q.ingress);
		end else if (dst_hit_q && (src_hit_q || (dst_idx_q != rp_q))) begin
			fwd_flood = 1'b0;
			fwd_mask  = act & (MASK_W'(1) << dst_port_q);
		end else begin
			fwd_flood = 1'b1;
			fwd_mask  = act & ~(MASK_W'(1) << item_q.ingress);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rmac_s1  <= mac_mem[rd_addr];
			rport_s1 <= port_mem[rd_addr];
			ridx_s1  <= rd_addr;
		end
		if (wr_en) begin
			port_mem[wr_addr] <= item_q.ingress;
			if (!src_hit_q) begin
				mac_mem[wr_addr] <= item_q.src_mac;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= qdata;
		end
		if (rvld_s1 && (rmac_s1 == item_q.src_mac)) begin
			src_idx_q <= ridx_s1;
		end
		if (rvld_s1 && (rmac_s1 == item_q.dst_mac)) begin
			dst_idx_q  <= ridx_s1;
			dst_port_q <= rport_s1;
		end
		if (pop) begin
			res_mask_q  <= '0;
			res_flood_q <= 1'b0;
			res_drop_q  <= 1'b1;
		end else if (wr_en) begin
			res_mask_q  <= fwd_mask;
			res_flood_q <= fwd_flood;
			res_drop_q  <= 1'b0;
		end
		if (emit_go) begin
			out_mask_q  <= res_mask_q;
			out_flood_q <= res_flood_q;
			out_drop_q  <= res_drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_q    <= '0;
			fill_q    <= '0;
			rp_q      <= '0;
			rvld_s1   <= 1'b0;
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rvld_s1 <= rd_en;
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						scan_q    <= '0;
						src_hit_q <= 1'b0;
						dst_hit_q <= 1'b0;
						state_q   <= qdata.short_frame ? S_EMIT : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rvld_s1 && (rmac_s1 == item_q.src_mac)) begin
						src_hit_q <= 1'b1;
					end
					if (rvld_s1 && (rmac_s1 == item_q.dst_mac)) begin
						dst_hit_q <= 1'b1;
					end
					if (!rd_en && !rvld_s1) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (!src_hit_q) begin
						rp_q <= (rp_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : rp_q + 1'b1;
						if (fill_q != CNT_W'(TABLE_ENTRIES)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/learning_switch_forwarder.sv @@
// Top level of the learning switch forwarder: port count register, front end,
// header queue and table engine. Depends on lsf_pkg, lsf_front, lsf_fifo and lsf_back.
`timescale 1ns / 1ps

// Forwarding decision of a learning Ethernet bridge.
// Each transfer on the s_axis channel carries one frame header. The block learns
// the source address against the ingress port and returns one transfer on the
// m_axis channel: the egress port mask in tdata, and the flooded and dropped
// flags in tuser. Frames shorter than 12 bytes are dropped and learn nothing.
// Headers pass a register stage in the front end and a four-entry queue, then
// the table engine scans the valid table entries one per cycle through the
// registered read port of the table memory, matching source and destination
// in the same pass, and then writes the learned entry in its write state.
// A header's time in the engine grows with the number of valid entries in the
// table; a short frame skips the scan and the write and goes straight to emit.
// The scan sets the rate; the front end keeps accepting headers into the queue
// while the engine works and while a result waits for the receiver.
// When m_axis_tready is low the result holds in the output register, the engine
// stalls once its next result is ready, and s_axis_tready falls when the queue fills.
// Reset empties the table (a fill count marks valid entries, so no clearing
// pass is needed) and sets port_count to 8. Write port_count through cfg_we and
// cfg_wdata only while no header is in flight.

module learning_switch_forwarder import lsf_pkg::*; #(
	parameter int unsigned PORTS         = PORTS_DEF,
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [PCOUNT_W-1:0] cfg_wdata,      // port_count
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// ingress_port [2:0], src_mac [50:3], dst_mac [98:51], frame_bytes [114:99], zeros above
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [MASK_W-1:0]   m_axis_tdata,   // egress_mask [7:0]
	output logic [FLAGS_W-1:0]  m_axis_tuser    // flooded [0], dropped [1]
);

	logic [PCOUNT_W-1:0] port_count_q;
	logic                push;
	lsf_item_t           push_item;
	logic                full;
	logic                pop;
	lsf_item_t           pop_item;
	logic                empty;
	logic                flooded;
	logic                dropped;

	// The active port count is the only configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_count_q <= PORT_COUNT_RST;
		end else if (cfg_we) begin
			port_count_q <= cfg_wdata;
		end
	end

	lsf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push          (push),
		.item          (push_item),
		.full          (full)
	);

	lsf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_item),
		.full   (full),
		.pop    (pop),
		.rdata  (pop_item),
		.empty  (empty)
	);

	lsf_back #(
		.PORTS         (PORTS),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.port_count  (port_count_q),
		.empty       (empty),
		.qdata       (pop_item),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_mask    (m_axis_tdata),
		.out_flooded (flooded),
		.out_dropped (dropped)
	);

	// Result flags share the user sideband, flooded in the low bit.
	assign m_axis_tuser = {dropped, flooded};

endmodule
